>>> hw/rtl/bws_pkg.sv
// ----------------------------------------------------------------------------
// bws_pkg
// Types and constants shared by the binned waveform statistics block.
// ----------------------------------------------------------------------------
package bws_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 8;
	localparam int BIN_SIZE_BITS = 17;
	localparam int INDEX_OUT_BITS = 16;
	localparam int MEAN_BITS     = 24;
	localparam int STDDEV_BITS   = 23;
	localparam int WORD_BITS     = 64;
	localparam int DIV_BITS      = WORD_BITS + 2 * FRACTION_BITS;
	localparam int DIV_STEP_BITS = $clog2(DIV_BITS + 1);
	localparam logic [WORD_BITS-1:0] STDDEV_MAX = WORD_BITS'((64'd1 << STDDEV_BITS) - 64'd1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          end_of_array;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_OUT_BITS-1:0]     first_index;
		logic signed [SAMPLE_BITS-1:0] bin_min;
		logic signed [SAMPLE_BITS-1:0] bin_max;
		logic signed [MEAN_BITS-1:0]   bin_mean;
		logic [STDDEV_BITS-1:0]        bin_stddev;
		logic                          last_bin;
		logic                          truncated;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MA_INIT,
		S_MA_RUN,
		S_MB_RUN,
		S_MC_RUN,
		S_MEAN_RUN,
		S_VAR_RUN,
		S_SQRT_RUN,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_MA_INIT,
		CMD_MB_INIT,
		CMD_MC_INIT,
		CMD_MUL_STEP,
		CMD_MEAN_INIT,
		CMD_VAR_INIT,
		CMD_DIV_STEP,
		CMD_SQRT_INIT,
		CMD_SQRT_STEP,
		CMD_OUT_LOAD
	} cmd_t;

	typedef struct packed {
		logic close;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage

>>> hw/rtl/bws_ctrl.sv
// ----------------------------------------------------------------------------
// bws_ctrl
// Sequencer that steps the datapath through the per-bin arithmetic.
// ----------------------------------------------------------------------------
module bws_ctrl import bws_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output logic    in_ready,
	output logic    take,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		take     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				take     = in_valid;
				if (in_valid && status.close) begin
					state_d = S_MA_INIT;
				end
			end
			S_MA_INIT: begin
				cmd     = CMD_MA_INIT;
				state_d = S_MA_RUN;
			end
			S_MA_RUN: begin
				if (status.mul_done) begin
					cmd     = CMD_MB_INIT;
					state_d = S_MB_RUN;
				end else begin
					cmd = CMD_MUL_STEP;
				end
			end
			S_MB_RUN: begin
				if (status.mul_done) begin
					cmd     = CMD_MC_INIT;
					state_d = S_MC_RUN;
				end else begin
					cmd = CMD_MUL_STEP;
				end
			end
			S_MC_RUN: begin
				if (status.mul_done) begin
					cmd     = CMD_MEAN_INIT;
					state_d = S_MEAN_RUN;
				end else begin
					cmd = CMD_MUL_STEP;
				end
			end
			S_MEAN_RUN: begin
				if (status.div_done) begin
					cmd     = CMD_VAR_INIT;
					state_d = S_VAR_RUN;
				end else begin
					cmd = CMD_DIV_STEP;
				end
			end
			S_VAR_RUN: begin
				if (status.div_done) begin
					cmd     = CMD_SQRT_INIT;
					state_d = S_SQRT_RUN;
				end else begin
					cmd = CMD_DIV_STEP;
				end
			end
			S_SQRT_RUN: begin
				if (status.sqrt_done) begin
					state_d = S_OUT;
				end else begin
					cmd = CMD_SQRT_STEP;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd     = CMD_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/bws_datapath.sv
// ----------------------------------------------------------------------------
// bws_datapath
// Bin accumulators, shift-add multiplier, restoring divider, square root
// and the output register.
// ----------------------------------------------------------------------------
module bws_datapath import bws_pkg::*; #(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [BIN_SIZE_BITS-1:0] cfg_data,
	input  logic                     take,
	input  in_item_t                 in_item,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic                     out_ready,
	output logic                     out_valid,
	output out_item_t                out_item
);

	localparam int IW   = $clog2(MAX_ELEMENTS + 1);
	localparam int SUMW = SAMPLE_BITS + IW;
	localparam int SQW  = 2 * SAMPLE_BITS - 1 + IW;

	logic [BIN_SIZE_BITS-1:0] bin_size_q;
	logic [IW-1:0]            idx_q;
	logic [IW-1:0]            cnt_q;
	logic [INDEX_OUT_BITS-1:0] start_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic signed [SUMW-1:0]   sum_q;
	logic [SQW-1:0]           sumsq_q;

	// Snapshot of the closed bin.
	logic [IW-1:0]            snap_cnt_q;
	logic signed [SUMW-1:0]   snap_sum_q;
	logic [SQW-1:0]           snap_sumsq_q;
	logic [INDEX_OUT_BITS-1:0] snap_start_q;
	logic signed [SAMPLE_BITS-1:0] snap_min_q, snap_max_q;
	logic                     snap_last_q, snap_trunc_q;

	logic [WORD_BITS-1:0] mcand_q, mplier_q, acc_q;
	logic [WORD_BITS-1:0] a_q, b_q, c2_q;
	logic [DIV_BITS-1:0]  dvd_q;
	logic [WORD_BITS-1:0] rem_q, divisor_q;
	logic [DIV_STEP_BITS-1:0] dstep_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [WORD_BITS-1:0] sx_q, sres_q, sbit_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic signed [SAMPLE_BITS-1:0]   s;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;
	logic [SQW-1:0]         sq;
	logic                   in_range, first, trunc, close;
	logic [IW-1:0]          idx_next, cnt_next;
	logic signed [SAMPLE_BITS-1:0] min_next, max_next;
	logic signed [SUMW-1:0] sum_next;
	logic [SQW-1:0]         sumsq_next;
	logic                   sum_neg;
	logic [WORD_BITS-1:0]   sum_ext, sum_mag, mean_word, var_diff;
	logic [WORD_BITS:0]     rem_shift;
	logic [WORD_BITS:0]     rem_sub;
	logic [WORD_BITS-1:0]   s_trial;

	always_comb begin
		s          = in_item.sample;
		sq_full    = s * s;
		sq         = SQW'($unsigned(sq_full));
		in_range   = idx_q < IW'(MAX_ELEMENTS);
		first      = cnt_q == '0;
		idx_next   = idx_q + IW'(1);
		cnt_next   = cnt_q + IW'(1);
		min_next   = (first || s < min_q) ? s : min_q;
		max_next   = (first || s > max_q) ? s : max_q;
		sum_next   = (first ? SUMW'(0) : sum_q) + SUMW'(s);
		sumsq_next = (first ? SQW'(0) : sumsq_q) + sq;
		trunc      = !in_item.end_of_array && (idx_next >= IW'(MAX_ELEMENTS));
		close      = in_range && (in_item.end_of_array || trunc ||
			(bin_size_q != '0 && 32'(cnt_next) >= 32'(bin_size_q)));

		sum_ext   = WORD_BITS'(snap_sum_q);
		sum_neg   = snap_sum_q < 0;
		sum_mag   = sum_neg ? (WORD_BITS'(0) - sum_ext) : sum_ext;
		mean_word = WORD_BITS'(dvd_q);
		var_diff  = (a_q > b_q) ? (a_q - b_q) : WORD_BITS'(0);
		rem_shift = {rem_q, dvd_q[DIV_BITS-1]};
		rem_sub   = rem_shift - {1'b0, divisor_q};
		s_trial   = sres_q + sbit_q;

		status.close     = close;
		status.mul_done  = mplier_q == '0;
		status.div_done  = dstep_q == '0;
		status.sqrt_done = sbit_q == '0;
		status.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q  <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bin_size_q <= cfg_data;
			end
			if (take) begin
				if (!in_range) begin
					if (in_item.end_of_array) begin
						idx_q <= '0;
					end
				end else begin
					idx_q <= in_item.end_of_array ? IW'(0) : idx_next;
					cnt_q <= close ? IW'(0) : cnt_next;
				end
			end
			if (cmd == CMD_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_range) begin
			if (first) begin
				start_q <= INDEX_OUT_BITS'(idx_q);
			end
			min_q   <= min_next;
			max_q   <= max_next;
			sum_q   <= sum_next;
			sumsq_q <= sumsq_next;
			if (close) begin
				snap_cnt_q   <= cnt_next;
				snap_sum_q   <= sum_next;
				snap_sumsq_q <= sumsq_next;
				snap_start_q <= first ? INDEX_OUT_BITS'(idx_q) : start_q;
				snap_min_q   <= min_next;
				snap_max_q   <= max_next;
				snap_last_q  <= in_item.end_of_array || trunc;
				snap_trunc_q <= trunc;
			end
		end

		case (cmd)
			CMD_MA_INIT: begin
				acc_q    <= '0;
				mcand_q  <= WORD_BITS'(snap_sumsq_q);
				mplier_q <= WORD_BITS'(snap_cnt_q);
			end
			CMD_MB_INIT: begin
				a_q      <= acc_q;
				acc_q    <= '0;
				mcand_q  <= sum_mag;
				mplier_q <= sum_mag;
			end
			CMD_MC_INIT: begin
				b_q      <= acc_q;
				acc_q    <= '0;
				mcand_q  <= WORD_BITS'(snap_cnt_q);
				mplier_q <= WORD_BITS'(snap_cnt_q);
			end
			CMD_MUL_STEP: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			CMD_MEAN_INIT: begin
				c2_q      <= acc_q;
				dvd_q     <= DIV_BITS'(sum_mag << FRACTION_BITS);
				divisor_q <= WORD_BITS'(snap_cnt_q);
				rem_q     <= '0;
				dstep_q   <= DIV_STEP_BITS'(DIV_BITS);
			end
			CMD_VAR_INIT: begin
				mean_q    <= MEAN_BITS'(sum_neg ? (WORD_BITS'(0) - mean_word) : mean_word);
				dvd_q     <= DIV_BITS'(var_diff) << (2 * FRACTION_BITS);
				divisor_q <= c2_q;
				rem_q     <= '0;
				dstep_q   <= DIV_STEP_BITS'(DIV_BITS);
			end
			CMD_DIV_STEP: begin
				// Restoring division: one quotient bit enters at the bottom.
				if (!rem_sub[WORD_BITS]) begin
					rem_q <= rem_sub[WORD_BITS-1:0];
					dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[WORD_BITS-1:0];
					dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
				end
				dstep_q <= dstep_q - DIV_STEP_BITS'(1);
			end
			CMD_SQRT_INIT: begin
				sx_q   <= WORD_BITS'(dvd_q);
				sres_q <= '0;
				sbit_q <= WORD_BITS'(1) << (WORD_BITS - 2);
			end
			CMD_SQRT_STEP: begin
				if (sx_q >= s_trial) begin
					sx_q   <= sx_q - s_trial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			CMD_OUT_LOAD: begin
				out_q.first_index <= snap_start_q;
				out_q.bin_min     <= snap_min_q;
				out_q.bin_max     <= snap_max_q;
				out_q.bin_mean    <= mean_q;
				out_q.bin_stddev  <= STDDEV_BITS'((sres_q > STDDEV_MAX) ? STDDEV_MAX : sres_q);
				out_q.last_bin    <= snap_last_q;
				out_q.truncated   <= snap_trunc_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> hw/rtl/binned_waveform_statistics.sv
// ----------------------------------------------------------------------------
// binned_waveform_statistics
// Per-bin min, max, mean and standard deviation of a sample stream.
// ----------------------------------------------------------------------------
// Samples enter on the in channel (valid/ready), one item each, with an end
// of array mark. The bin size register is written through cfg_we/cfg_data;
// the user must write it only while the block is idle; the block does not
// enforce this. Zero makes the whole array one bin. A sample that does not
// close a bin leaves the block ready for the next one. A sample that closes
// a bin starts the result sequence, during which in_ready is low: three
// shift-add multiplies (one multiplier bit per cycle), two 80-step restoring
// divisions and a 32-step square root. That shared iterative arithmetic
// sets the bin rate.
// The result goes to an output register; the block takes new samples while
// a result waits there. If out_ready stays low, a second finished bin waits
// in the sequencer until the register frees up.
// Reset clears the bin state, the array index, the bin size and out_valid.
// ----------------------------------------------------------------------------
module binned_waveform_statistics import bws_pkg::*; #(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [BIN_SIZE_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output out_item_t                out_item
);

	status_t status;
	cmd_t    cmd;
	logic    take;

	bws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_ready (in_ready),
		.take     (take),
		.cmd      (cmd)
	);

	bws_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.take      (take),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	a_close_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && status.close |=> !in_ready)
		else $error("input still ready after a closing item");
	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_item.truncated || out_item.last_bin))
		else $error("truncated bin not marked last");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.bin_min <= out_item.bin_max))
		else $error("bin min above bin max");
`endif

endmodule
